// ----- rtl/smws_pkg.sv -----
// ----------------------------------------------------------------------------
// smws_pkg
// Shared types, register indexes and bit helpers for the SPI word shifter.
// ----------------------------------------------------------------------------
package smws_pkg;

   localparam int WORD_W        = 32;
   localparam int MAX_WORD_BITS = 32;
   localparam int BITS_W        = 6;
   localparam int IDX_W         = 5;
   localparam int HALF_W        = 16;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 40;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLOCK_POLARITY = 3'd0,
      CSR_CLOCK_PHASE    = 3'd1,
      CSR_LSB_FIRST      = 3'd2,
      CSR_WORD_BITS      = 3'd3,
      CSR_HALF_PERIOD    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic              clock_polarity;
      logic              clock_phase;
      logic              lsb_first;
      logic [BITS_W-1:0] word_bits;
      logic [HALF_W-1:0] half_period_ticks;
   } cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0] tx_shift;
      logic [WORD_W-1:0] rx_shift;
      logic [IDX_W-1:0]  bit_index;
      logic              second_half;
      logic [HALF_W-1:0] tick_count;
      logic              active;
      logic              clock_out;
      logic              data_out;
   } state_type;

   typedef struct packed {
      logic              sclk_level;
      logic              mosi_level;
      logic              busy_res;
      logic              rx_valid;
      logic [WORD_W-1:0] rx_word;
   } result_type;

   // Clamp the programmed word length into 1..MAX_WORD_BITS.
   function automatic logic [BITS_W-1:0] eff_bits(input logic [BITS_W-1:0] n);
      logic [BITS_W-1:0] r;
      r = n;
      if (n == '0) begin
         r = BITS_W'(1);
      end else if (n > BITS_W'(MAX_WORD_BITS)) begin
         r = BITS_W'(MAX_WORD_BITS);
      end
      return r;
   endfunction

   // Ones in the low n bits, n in 1..WORD_W.
   function automatic logic [WORD_W-1:0] low_mask(input logic [BITS_W-1:0] n);
      logic [BITS_W-1:0] sh;
      sh = BITS_W'(WORD_W) - n;
      return {WORD_W{1'b1}} >> sh;
   endfunction

   // Reverse the low n bits of v, n in 1..WORD_W; v must be zero above n.
   function automatic logic [WORD_W-1:0] flip_bits(input logic [WORD_W-1:0] v,
                                                   input logic [BITS_W-1:0] n);
      logic [WORD_W-1:0] rev;
      logic [BITS_W-1:0] sh;
      for (int k = 0; k < WORD_W; k++) begin
         rev[WORD_W-1-k] = v[k];
      end
      sh = BITS_W'(WORD_W) - n;
      return rev >> sh;
   endfunction

endpackage

// ----- rtl/smws_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// smws_cfg_regs
// Control register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module smws_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [smws_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [smws_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output smws_pkg::cfg_type                   cfg
);

   smws_pkg::cfg_type cfg_ff;
   smws_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            smws_pkg::CSR_CLOCK_POLARITY: cfg_in.clock_polarity = csr_wdata[0];
            smws_pkg::CSR_CLOCK_PHASE:    cfg_in.clock_phase    = csr_wdata[0];
            smws_pkg::CSR_LSB_FIRST:      cfg_in.lsb_first      = csr_wdata[0];
            smws_pkg::CSR_WORD_BITS:
               cfg_in.word_bits = csr_wdata[smws_pkg::BITS_W-1:0];
            smws_pkg::CSR_HALF_PERIOD:
               cfg_in.half_period_ticks = csr_wdata[smws_pkg::HALF_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_polarity    <= 1'b0;
         cfg_ff.clock_phase       <= 1'b0;
         cfg_ff.lsb_first         <= 1'b0;
         cfg_ff.word_bits         <= smws_pkg::BITS_W'(8);
         cfg_ff.half_period_ticks <= smws_pkg::HALF_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/smws_engine.sv -----
// ----------------------------------------------------------------------------
// smws_engine
// One tick of the serial engine: next shifter state and the tick's line levels.
// ----------------------------------------------------------------------------
module smws_engine (
   input  smws_pkg::cfg_type                cfg,
   input  smws_pkg::state_type              st,
   input  logic                             start_req,
   input  logic [smws_pkg::WORD_W-1:0]      tx_word,
   input  logic                             miso_level,
   output smws_pkg::state_type              st_next,
   output smws_pkg::result_type             res
);

   logic [smws_pkg::BITS_W-1:0] n_bits;
   logic [smws_pkg::HALF_W-1:0] half;
   logic [smws_pkg::WORD_W-1:0] load_word;
   logic [smws_pkg::WORD_W-1:0] mask;
   logic [smws_pkg::IDX_W-1:0]  next_index;

   assign n_bits     = smws_pkg::eff_bits(cfg.word_bits);
   assign half       = (cfg.half_period_ticks == '0) ? smws_pkg::HALF_W'(1)
                                                     : cfg.half_period_ticks;
   assign mask       = smws_pkg::low_mask(n_bits);
   assign load_word  = cfg.lsb_first ? smws_pkg::flip_bits(tx_word & mask, n_bits)
                                     : (tx_word & mask);
   assign next_index = st.bit_index - smws_pkg::IDX_W'(1);

   always_comb begin
      st_next         = st;
      res.rx_valid    = 1'b0;
      res.rx_word     = '0;
      if (!st.active) begin
         st_next.clock_out = cfg.clock_polarity;
         if (start_req) begin
            st_next.tx_shift    = load_word;
            st_next.rx_shift    = '0;
            st_next.bit_index   = smws_pkg::IDX_W'(n_bits - smws_pkg::BITS_W'(1));
            st_next.second_half = 1'b0;
            st_next.tick_count  = smws_pkg::HALF_W'(1);
            st_next.active      = 1'b1;
            st_next.data_out    =
               load_word[smws_pkg::IDX_W'(n_bits - smws_pkg::BITS_W'(1))];
            st_next.clock_out   = cfg.clock_polarity ^ cfg.clock_phase;
         end
      end else if (st.tick_count < half) begin
         st_next.tick_count = st.tick_count + smws_pkg::HALF_W'(1);
      end else if (!st.second_half) begin
         // Middle edge: sample MISO on it, for either phase.
         st_next.second_half = 1'b1;
         st_next.tick_count  = smws_pkg::HALF_W'(1);
         st_next.clock_out   = cfg.clock_polarity ^ ~cfg.clock_phase;
         st_next.rx_shift[st.bit_index] = st.rx_shift[st.bit_index] | miso_level;
      end else if (st.bit_index == '0) begin
         st_next.active      = 1'b0;
         st_next.second_half = 1'b0;
         st_next.clock_out   = cfg.clock_polarity;
         res.rx_valid        = 1'b1;
         res.rx_word         = cfg.lsb_first
                               ? smws_pkg::flip_bits(st.rx_shift & mask, n_bits)
                               : st.rx_shift;
      end else begin
         st_next.bit_index   = next_index;
         st_next.second_half = 1'b0;
         st_next.tick_count  = smws_pkg::HALF_W'(1);
         st_next.data_out    = st.tx_shift[next_index];
         st_next.clock_out   = cfg.clock_polarity ^ cfg.clock_phase;
      end
      res.sclk_level = st_next.clock_out;
      res.mosi_level = st_next.data_out;
      res.busy_res   = st_next.active;
   end

endmodule

// ----- rtl/spi_master_word_shifter_unit.sv -----
// ----------------------------------------------------------------------------
// spi_master_word_shifter_unit
// SPI master (modes 0 to 3) stepped one serial-engine tick per input word.
//
//  channel | direction | handshake              | contents
//  --------+-----------+------------------------+------------------------------
//  req_    | in        | req_tvalid/req_tready  | start, tx word, MISO level
//  rsp_    | out       | rsp_tvalid/rsp_tready  | SCLK, MOSI, busy, rx word
//  csr_    | in        | csr_we (no wait)       | mode, length, half period
//
// Each accepted input word advances the engine by one tick and yields exactly
// one result word; one word per cycle when the result side keeps up. The
// shifter state and the result register load on the same edge. The result
// register is the only buffer: hold input while it is full and not being
// taken. Reset (synchronous) idles the engine, clears the shifters and loads
// default registers: mode 0, MSB first, 8 bits, 1 tick.
// ----------------------------------------------------------------------------
module spi_master_word_shifter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input words
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] start_req, [32:1] tx_word, [33] miso_level, [39:34] zero
   input  logic [smws_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Result words
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] sclk_level, [1] mosi_level, [2] busy_res, [3] rx_valid,
   // [35:4] rx_word, [39:36] zero
   output logic [smws_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Register writes
   input  logic                                 csr_we,
   input  logic [smws_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [smws_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   smws_pkg::cfg_type    cfg;
   smws_pkg::state_type  state_ff;
   smws_pkg::state_type  state_in;
   smws_pkg::result_type res_ff;
   smws_pkg::result_type res_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 req_fire;

   // Unpack the input word.
   logic                            start_req;
   logic [smws_pkg::WORD_W-1:0]     tx_word;
   logic                            miso_level;

   assign start_req  = req_tdata[0];
   assign tx_word    = req_tdata[smws_pkg::WORD_W:1];
   assign miso_level = req_tdata[smws_pkg::WORD_W+1];

   smws_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   smws_engine u_engine (
      .cfg        (cfg),
      .st         (state_ff),
      .start_req  (start_req),
      .tx_word    (tx_word),
      .miso_level (miso_level),
      .st_next    (state_in),
      .res        (res_in)
   );

   // Take a new word whenever the result register is empty or drains now.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Advance the engine only on accepted ticks.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Result payload: load with the tick, no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, res_ff.rx_word, res_ff.rx_valid, res_ff.busy_res,
                        res_ff.mosi_level, res_ff.sclk_level};

   // A transfer that ends leaves its completion result in the output register.
   a_end_gives_word: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff.active) |-> (rsp_valid_ff && res_ff.rx_valid))
      else $error("transfer ended without a valid received word");

   // The half-period counter never sits at zero during a transfer.
   a_tick_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |-> (state_ff.tick_count != '0))
      else $error("tick counter zero while busy");

   // Idle engine never holds the second-half flag.
   a_idle_first_half: assert property (@(posedge clock) disable iff (reset)
      !state_ff.active |-> !state_ff.second_half)
      else $error("second half flagged while idle");

endmodule
